### hdl/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Shared constants, codes and control/status types of the text console
// character writer.
// ============================================================================
package tcw_pkg;

    // Screen geometry
    localparam int WIDTH  = 80;
    localparam int HEIGHT = 25;

    // Cursor values run up to and including WIDTH / HEIGHT
    localparam int COL_W     = $clog2(WIDTH + 1);
    localparam int ROW_W     = $clog2(HEIGHT + 1);
    localparam int COL_IDX_W = $clog2(WIDTH);
    localparam int ROW_IDX_W = $clog2(HEIGHT);
    localparam int CELLS     = WIDTH * HEIGHT;
    localparam int ADDR_W    = $clog2(CELLS);

    // Field widths on the stream ports
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int IN_DW    = 24;
    localparam int OUT_DW   = 24;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // latch the input transfer
        logic exec_simple;  // cursor update (clear also resets rows), load result
        logic prep;         // wrap / scroll before a printable write
        logic put;          // store character, advance, load result
        logic blank;        // write one space of a row blank sweep
        logic rd_issue;     // start cell read
        logic rd_done;      // load result with the read cell
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_print;     // latched item is a printable write
        logic op_read;      // latched item is a cell read
        logic row_ok;       // cursor row holds initialized cells
        logic blank_last;   // sweep is on the last column
    } sts_t;

endpackage

### hdl/text_console_char_writer.sv
// ============================================================================
// text_console_char_writer
// Text-mode character buffer with a cursor: writes, clears and cell reads.
// ============================================================================
// Control characters, clear and unused commands are latched, then executed into the
//   result register; cell reads and printable writes load it from a further state.
// A printable write into a row not touched since reset, clear or scroll first
//   blanks that row in the cell RAM, one cell per cycle.
// The single RAM port and the one-item-at-a-time sequencer take no new item until
//   the current one has loaded its result; none is taken during a blank sweep.
// Reset clears cursor, scroll offset and per-row initialized flags; there is
//   no clearing pass, rows not yet initialized read back as spaces.
module text_console_char_writer (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // cursor_col[6:0], cursor_row[11:7], cell_char[19:12], zero pad
);

    tcw_pkg::ctl_t ctl;
    tcw_pkg::sts_t sts;

    logic [tcw_pkg::OCOL_W-1:0] cursor_col;
    logic [tcw_pkg::OROW_W-1:0] cursor_row;
    logic [tcw_pkg::CHAR_W-1:0] cell_char;

    // Sequencer: one item in flight, result register decouples the output side
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Cursor, ring-ordered rows in the cell RAM, result register
    tcw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cmd        (s_tuser),
        .char_code  (s_tdata[7:0]),
        .read_row   (s_tdata[12:8]),
        .read_col   (s_tdata[19:13]),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char)
    );

    // pack result transfer, fields from the low end
    assign m_tdata = {4'b0, cell_char, cursor_row, cursor_col};

endmodule

### hdl/tcw_ram.sv
// ============================================================================
// tcw_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module tcw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/tcw_ctrl.sv
// ============================================================================
// tcw_ctrl
// Sequencer: accepts one item, steps the datapath through it and owns the
// result-valid flag.
// ============================================================================
module tcw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  tcw_pkg::sts_t sts,
    output tcw_pkg::ctl_t ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_BLANK = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // result register can take a new value this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ctl            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.op_print)
                begin
                    ctl.prep   = 1'b1;
                    state_next = S_PUT;
                end
                else if (sts.op_read)
                begin
                    ctl.rd_issue = 1'b1;
                    state_next   = S_RD;
                end
                else if (out_free)
                begin
                    ctl.exec_simple = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_PUT:
            begin
                if (!sts.row_ok)
                begin
                    state_next = S_BLANK;
                end
                else if (out_free)
                begin
                    ctl.put        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_BLANK:
            begin
                ctl.blank = 1'b1;
                if (sts.blank_last)
                begin
                    state_next = S_PUT;
                end
            end
            S_RD:
            begin
                if (out_free)
                begin
                    ctl.rd_done    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

### hdl/tcw_dp.sv
// ============================================================================
// tcw_dp
// Datapath: cursor, scroll offset, per-row initialized flags, cell RAM
// addressing and the result register.
// ============================================================================
module tcw_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcw_pkg::ctl_t                ctl,
    output tcw_pkg::sts_t                sts,
    input  logic [tcw_pkg::CMD_W-1:0]    cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::RROW_W-1:0]   read_row,
    input  logic [tcw_pkg::RCOL_W-1:0]   read_col,
    output logic [tcw_pkg::OCOL_W-1:0]   cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]   cell_char
);

    // latched item
    logic [tcw_pkg::CMD_W-1:0]     cmd_reg;
    logic [tcw_pkg::CHAR_W-1:0]    ch_reg;
    logic [tcw_pkg::RROW_W-1:0]    rr_reg;
    logic [tcw_pkg::RCOL_W-1:0]    rc_reg;

    // cursor and screen bookkeeping
    logic [tcw_pkg::COL_W-1:0]     col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [tcw_pkg::ROW_IDX_W-1:0] top_reg, top_next;
    logic [tcw_pkg::HEIGHT-1:0]    valid_reg, valid_next;
    logic [tcw_pkg::COL_IDX_W-1:0] cnt_reg, cnt_next;

    // result register
    logic [tcw_pkg::OCOL_W-1:0]    res_col_reg, res_col_next;
    logic [tcw_pkg::OROW_W-1:0]    res_row_reg, res_row_next;
    logic [tcw_pkg::CHAR_W-1:0]    res_cell_reg, res_cell_next;

    logic                          is_ctrl_ch;
    logic [tcw_pkg::ROW_W-1:0]     row_inc;
    logic [tcw_pkg::COL_W:0]       tab_sum;
    logic [tcw_pkg::COL_W:0]       tab_mask;
    logic [tcw_pkg::COL_W-1:0]     tab_col;
    logic [tcw_pkg::COL_W-1:0]     scol;
    logic [tcw_pkg::ROW_W-1:0]     srow;
    logic                          wrap;
    logic [tcw_pkg::ROW_W-1:0]     row_w;
    logic                          scroll;
    logic [tcw_pkg::ROW_W-1:0]     row_p;
    logic [tcw_pkg::ROW_IDX_W-1:0] top_inc;

    logic                          rd_mode;
    logic                          in_range;
    logic [tcw_pkg::ROW_IDX_W-1:0] row_sel;
    logic [tcw_pkg::COL_IDX_W-1:0] col_sel;
    logic [tcw_pkg::ROW_IDX_W:0]   phys_sum;
    logic [tcw_pkg::ROW_IDX_W-1:0] phys;
    logic [tcw_pkg::ADDR_W-1:0]    addr;
    logic                          ram_we;
    logic [tcw_pkg::CHAR_W-1:0]    ram_wdata;
    logic [tcw_pkg::CHAR_W-1:0]    ram_rdata;
    logic                          rd_ok;

    // ---------------------------------------------------------------- decode
    assign is_ctrl_ch = (ch_reg == tcw_pkg::CH_NEWLINE) || (ch_reg == tcw_pkg::CH_RETURN)
                     || (ch_reg == tcw_pkg::CH_BACKSPACE) || (ch_reg == tcw_pkg::CH_TAB);
    assign sts.op_print = (cmd_reg == tcw_pkg::CMD_WRITE) && !is_ctrl_ch;
    assign sts.op_read  = (cmd_reg == tcw_pkg::CMD_READ);

    // ----------------------------------------------------- cursor arithmetic
    assign row_inc  = (row_reg < tcw_pkg::ROW_W'(tcw_pkg::HEIGHT)) ? row_reg + 1'b1 : row_reg;
    assign tab_sum  = (tcw_pkg::COL_W + 1)'(col_reg) + (tcw_pkg::COL_W + 1)'(4);
    assign tab_mask = tab_sum & ~(tcw_pkg::COL_W + 1)'(3);
    assign tab_col  = (tab_mask > (tcw_pkg::COL_W + 1)'(tcw_pkg::WIDTH))
                    ? tcw_pkg::COL_W'(tcw_pkg::WIDTH) : tab_mask[tcw_pkg::COL_W-1:0];

    always_comb
    begin
        scol = col_reg;
        srow = row_reg;
        if (cmd_reg == tcw_pkg::CMD_WRITE)
        begin
            priority if (ch_reg == tcw_pkg::CH_NEWLINE)
            begin
                srow = row_inc;
                scol = '0;
            end
            else if (ch_reg == tcw_pkg::CH_RETURN)
            begin
                scol = '0;
            end
            else if (ch_reg == tcw_pkg::CH_BACKSPACE)
            begin
                if (col_reg != '0)
                begin
                    scol = col_reg - 1'b1;
                end
            end
            else if (ch_reg == tcw_pkg::CH_TAB)
            begin
                scol = tab_col;
            end
        end
        else if (cmd_reg == tcw_pkg::CMD_CLEAR)
        begin
            scol = '0;
            srow = '0;
        end
    end

    // wrap and scroll ahead of a printable store
    assign wrap    = (col_reg >= tcw_pkg::COL_W'(tcw_pkg::WIDTH));
    assign row_w   = wrap ? row_inc : row_reg;
    assign scroll  = (row_w >= tcw_pkg::ROW_W'(tcw_pkg::HEIGHT));
    assign row_p   = scroll ? tcw_pkg::ROW_W'(tcw_pkg::HEIGHT - 1) : row_w;
    assign top_inc = (top_reg == tcw_pkg::ROW_IDX_W'(tcw_pkg::HEIGHT - 1))
                   ? '0 : top_reg + 1'b1;

    // ------------------------------------------------------- cell addressing
    // Logical row r lives in physical row (r + top) mod HEIGHT.
    assign rd_mode  = (cmd_reg == tcw_pkg::CMD_READ);
    assign in_range = (32'(rr_reg) < 32'(tcw_pkg::HEIGHT)) && (32'(rc_reg) < 32'(tcw_pkg::WIDTH));
    assign row_sel  = rd_mode ? tcw_pkg::ROW_IDX_W'(rr_reg) : tcw_pkg::ROW_IDX_W'(row_reg);
    assign col_sel  = ctl.blank ? cnt_reg
                    : (rd_mode ? tcw_pkg::COL_IDX_W'(rc_reg) : tcw_pkg::COL_IDX_W'(col_reg));
    assign phys_sum = (tcw_pkg::ROW_IDX_W + 1)'(row_sel) + (tcw_pkg::ROW_IDX_W + 1)'(top_reg);
    assign phys     = (phys_sum >= (tcw_pkg::ROW_IDX_W + 1)'(tcw_pkg::HEIGHT))
                    ? tcw_pkg::ROW_IDX_W'(phys_sum - (tcw_pkg::ROW_IDX_W + 1)'(tcw_pkg::HEIGHT))
                    : tcw_pkg::ROW_IDX_W'(phys_sum);
    assign addr     = tcw_pkg::ADDR_W'(phys) * tcw_pkg::ADDR_W'(tcw_pkg::WIDTH)
                    + tcw_pkg::ADDR_W'(col_sel);

    assign ram_we    = ctl.put || ctl.blank;
    assign ram_wdata = ctl.blank ? tcw_pkg::CH_SPACE : ch_reg;

    assign sts.row_ok     = valid_reg[phys];
    assign sts.blank_last = (cnt_reg == tcw_pkg::COL_IDX_W'(tcw_pkg::WIDTH - 1));

    // rows never written since reset, clear or scroll read as spaces
    assign rd_ok = in_range && valid_reg[phys];

    tcw_ram #(
        .DATA_W (tcw_pkg::CHAR_W),
        .DEPTH  (tcw_pkg::CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .re    (ctl.rd_issue),
        .addr  (addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------ next state
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        top_next      = top_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        res_col_next  = res_col_reg;
        res_row_next  = res_row_reg;
        res_cell_next = res_cell_reg;
        if (ctl.exec_simple)
        begin
            col_next      = scol;
            row_next      = srow;
            res_col_next  = tcw_pkg::OCOL_W'(scol);
            res_row_next  = tcw_pkg::OROW_W'(srow);
            res_cell_next = '0;
            if (cmd_reg == tcw_pkg::CMD_CLEAR)
            begin
                valid_next = '0;
                top_next   = '0;
            end
        end
        if (ctl.prep)
        begin
            col_next = wrap ? '0 : col_reg;
            row_next = row_p;
            cnt_next = '0;
            if (scroll)
            begin
                // old top row becomes the new bottom row, blank until swept
                valid_next[top_reg] = 1'b0;
                top_next            = top_inc;
            end
        end
        if (ctl.blank)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (sts.blank_last)
            begin
                valid_next[phys] = 1'b1;
            end
        end
        if (ctl.put)
        begin
            col_next      = col_reg + 1'b1;
            res_col_next  = tcw_pkg::OCOL_W'(col_reg + 1'b1);
            res_row_next  = tcw_pkg::OROW_W'(row_reg);
            res_cell_next = '0;
        end
        if (ctl.rd_done)
        begin
            res_col_next  = tcw_pkg::OCOL_W'(col_reg);
            res_row_next  = tcw_pkg::OROW_W'(row_reg);
            res_cell_next = in_range ? (rd_ok ? ram_rdata : tcw_pkg::CH_SPACE) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            top_reg   <= '0;
            valid_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            top_reg   <= top_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= cmd;
            ch_reg  <= char_code;
            rr_reg  <= read_row;
            rc_reg  <= read_col;
        end
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_cell_reg <= res_cell_next;
    end

    assign cursor_col = res_col_reg;
    assign cursor_row = res_row_reg;
    assign cell_char  = res_cell_reg;

    // -------------------------------------------------------------- checks
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.put |-> (row_reg < tcw_pkg::ROW_W'(tcw_pkg::HEIGHT))
                    && (col_reg < tcw_pkg::COL_W'(tcw_pkg::WIDTH)))
        else $error("store with cursor outside the screen");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.put |-> valid_reg[phys])
        else $error("store into a row that was not blanked");

    assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg < tcw_pkg::ROW_IDX_W'(tcw_pkg::HEIGHT))
        && (row_reg <= tcw_pkg::ROW_W'(tcw_pkg::HEIGHT))
        && (col_reg <= tcw_pkg::COL_W'(tcw_pkg::WIDTH)))
        else $error("cursor or scroll offset out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.prep && scroll) |=> !valid_reg[$past(top_reg)])
        else $error("scrolled-in row still marked initialized");

endmodule

### test/text_console_char_writer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// text_console_char_writer_tb
// Self-checking bench for the text console character writer. A shadow copy
// of the screen and cursor predicts every result. Stimulus is a short list
// of edge cases, then runs of text lines, newline bursts, cell reads and
// noise, sent under several sender/receiver idle mixes plus one long output
// hold-off that backs the block up.
// ============================================================================
module text_console_char_writer_tb;

    // cmd 3 has no name in the package; the block just reports the cursor
    localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES = tcw_pkg::WIDTH + 40;   // covers a blank sweep plus latency

    // One result transfer as the block should produce it
    typedef struct {
        logic [tcw_pkg::OCOL_W-1:0] col;
        logic [tcw_pkg::OROW_W-1:0] row;
        logic [tcw_pkg::CHAR_W-1:0] cell_char;
    } console_result_t;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [tcw_pkg::IN_DW-1:0]  s_tdata  = '0;
    logic [tcw_pkg::CMD_W-1:0]  s_tuser  = tcw_pkg::CMD_WRITE;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [tcw_pkg::OUT_DW-1:0] m_tdata;

    // Shadow of the block's state
    logic [tcw_pkg::CHAR_W-1:0] shadow_screen [tcw_pkg::CELLS];
    int                         shadow_col;
    int                         shadow_row;

    console_result_t   console_results_q [$];

    // Handshake pacing, set per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;     // long output hold-off, counted down below

    // Bookkeeping
    int errors      = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_scrolls   = 0;
    int n_wraps     = 0;
    int n_tab_clamp = 0;
    int n_reads_oor = 0;

    text_console_char_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------
    function automatic void blank_screen();
        foreach (shadow_screen[i])
            shadow_screen[i] = tcw_pkg::CH_SPACE;
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    // Applies one command to the shadow state and returns the result it gives
    function automatic console_result_t apply_console_item(
        logic [tcw_pkg::CMD_W-1:0]  cmd,
        logic [tcw_pkg::CHAR_W-1:0] ch,
        logic [tcw_pkg::RROW_W-1:0] rr,
        logic [tcw_pkg::RCOL_W-1:0] rc
    );
        console_result_t res;
        int              t;
        res.cell_char = '0;
        case (cmd)
            tcw_pkg::CMD_WRITE:
            begin
                if (ch == tcw_pkg::CH_NEWLINE)
                begin
                    if (shadow_row < tcw_pkg::HEIGHT)
                        shadow_row++;
                    shadow_col = 0;
                end
                else if (ch == tcw_pkg::CH_RETURN)
                    shadow_col = 0;
                else if (ch == tcw_pkg::CH_BACKSPACE)
                begin
                    if (shadow_col > 0)
                        shadow_col--;
                end
                else if (ch == tcw_pkg::CH_TAB)
                begin
                    t = (shadow_col + 4) & ~3;
                    if (t > tcw_pkg::WIDTH)
                        n_tab_clamp++;
                    shadow_col = (t > tcw_pkg::WIDTH) ? tcw_pkg::WIDTH : t;
                end
                else
                begin
                    // past the right edge: wrap first
                    if (shadow_col >= tcw_pkg::WIDTH)
                    begin
                        shadow_col = 0;
                        if (shadow_row < tcw_pkg::HEIGHT)
                            shadow_row++;
                        n_wraps++;
                    end
                    // below the bottom: scroll up one row, blank the last
                    if (shadow_row >= tcw_pkg::HEIGHT)
                    begin
                        for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::WIDTH; i++)
                            shadow_screen[i] = shadow_screen[i + tcw_pkg::WIDTH];
                        for (int i = tcw_pkg::CELLS - tcw_pkg::WIDTH; i < tcw_pkg::CELLS; i++)
                            shadow_screen[i] = tcw_pkg::CH_SPACE;
                        shadow_row = tcw_pkg::HEIGHT - 1;
                        n_scrolls++;
                    end
                    shadow_screen[shadow_row * tcw_pkg::WIDTH + shadow_col] = ch;
                    shadow_col++;
                end
            end
            tcw_pkg::CMD_CLEAR:
                blank_screen();
            tcw_pkg::CMD_READ:
            begin
                if (rr < tcw_pkg::HEIGHT && rc < tcw_pkg::WIDTH)
                    res.cell_char = shadow_screen[rr * tcw_pkg::WIDTH + rc];
                else
                    n_reads_oor++;
            end
            default:
                ;
        endcase
        res.col = shadow_col[tcw_pkg::OCOL_W-1:0];
        res.row = shadow_row[tcw_pkg::OROW_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one transfer per call, driven at the falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(
        logic [tcw_pkg::CMD_W-1:0]  cmd,
        logic [tcw_pkg::CHAR_W-1:0] ch,
        logic [tcw_pkg::RROW_W-1:0] rr,
        logic [tcw_pkg::RCOL_W-1:0] rc
    );
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(tcw_pkg::IN_DW - 20){1'b0}}, rc, rr, ch};
        do
            @(posedge clk);
        while (!s_tready);
        console_results_q.push_back(apply_console_item(cmd, ch, rr, rc));
        n_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready pattern and result check
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (console_results_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result col %0d row %0d cell %02h", $time,
                         m_tdata[6:0], m_tdata[11:7], m_tdata[19:12]);
            end
            else
            begin
                want = console_results_q.pop_front();
                n_checked++;
                if (m_tdata[6:0] !== want.col || m_tdata[11:7] !== want.row ||
                    m_tdata[19:12] !== want.cell_char)
                begin
                    errors++;
                    $display("%0t: mismatch exp col %0d row %0d cell %02h, got col %0d row %0d cell %02h",
                             $time, want.col, want.row, want.cell_char,
                             m_tdata[6:0], m_tdata[11:7], m_tdata[19:12]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, each control code and the odd corners of reads/commands
    task automatic test_directed_cases();
        send_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);         // fresh screen reads space
        send_item(tcw_pkg::CMD_WRITE, 8'h00, 5'd0, 7'd0);        // lowest byte is printable
        send_item(tcw_pkg::CMD_WRITE, 8'hFF, 5'd31, 7'd127);     // highest byte, noisy read fields
        send_item(tcw_pkg::CMD_WRITE, "A", 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_READ, 8'hFF, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd1);
        send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_TAB, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_TAB, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_RETURN, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0); // stays at column 0
        send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, 8'h7E, 5'd0, 7'd0);
        send_item(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);             // no effect, cursor only
        send_item(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd0);
        send_item(tcw_pkg::CMD_READ, 8'h00, tcw_pkg::RROW_W'(tcw_pkg::HEIGHT - 1),
                  tcw_pkg::RCOL_W'(tcw_pkg::WIDTH - 1));
        // row just off the screen
        send_item(tcw_pkg::CMD_READ, 8'h00, tcw_pkg::RROW_W'(tcw_pkg::HEIGHT), 7'd0);
        // column just off the screen
        send_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, tcw_pkg::RCOL_W'(tcw_pkg::WIDTH));
        send_item(tcw_pkg::CMD_READ, 8'hFF, 5'd31, 7'd127);
        send_item(tcw_pkg::CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
        send_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_SPACE, 5'd0, 7'd0);
    endtask

    // Mostly well-formed console traffic with random content
    task automatic test_traffic(int n_items, int idle_pct, int stall_pct);
        int                         sent;
        int                         kind;
        int                         len;
        int                         r;
        logic [tcw_pkg::CHAR_W-1:0] ch;
        logic [tcw_pkg::RROW_W-1:0] rr;
        logic [tcw_pkg::RCOL_W-1:0] rc;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                // a line of text; long ones run past the right edge
                len = ($urandom_range(3) == 0) ? $urandom_range(100, 60) : $urandom_range(30);
                for (int i = 0; i < len; i++)
                begin
                    r = $urandom_range(99);
                    if (r < 5)
                        ch = tcw_pkg::CH_TAB;
                    else if (r < 10)
                        ch = tcw_pkg::CH_BACKSPACE;
                    else if (r < 80)
                        ch = tcw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h21));
                    else
                        ch = tcw_pkg::CHAR_W'($urandom_range(255));
                    send_item(tcw_pkg::CMD_WRITE, ch, tcw_pkg::RROW_W'($urandom_range(31)),
                              tcw_pkg::RCOL_W'($urandom_range(127)));
                end
                send_item(tcw_pkg::CMD_WRITE,
                          ($urandom_range(4) == 0) ? tcw_pkg::CH_RETURN : tcw_pkg::CH_NEWLINE,
                          tcw_pkg::RROW_W'($urandom_range(31)),
                          tcw_pkg::RCOL_W'($urandom_range(127)));
                sent += len + 1;
            end
            else if (kind < 60)
            begin
                // newline burst, often enough to hit the bottom
                len = $urandom_range(30, 1);
                for (int i = 0; i < len; i++)
                    send_item(tcw_pkg::CMD_WRITE, tcw_pkg::CH_NEWLINE,
                              tcw_pkg::RROW_W'($urandom_range(31)),
                              tcw_pkg::RCOL_W'($urandom_range(127)));
                sent += len;
            end
            else if (kind < 85)
            begin
                // cell reads, mostly among written rows
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        rr = tcw_pkg::RROW_W'($urandom_range(31));
                        rc = tcw_pkg::RCOL_W'($urandom_range(127));
                    end
                    else
                    begin
                        rr = tcw_pkg::RROW_W'($urandom_range(
                            (shadow_row < tcw_pkg::HEIGHT) ? shadow_row : tcw_pkg::HEIGHT - 1));
                        rc = tcw_pkg::RCOL_W'($urandom_range(tcw_pkg::WIDTH - 1));
                    end
                    send_item(tcw_pkg::CMD_READ, tcw_pkg::CHAR_W'($urandom_range(255)), rr, rc);
                end
                sent += len;
            end
            else if (kind < 97)
            begin
                // noise: random bytes, reads and the unused command
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                begin
                    r = $urandom_range(2);
                    send_item((r == 0) ? tcw_pkg::CMD_WRITE
                              : (r == 1) ? tcw_pkg::CMD_READ : CMD_UNUSED,
                              tcw_pkg::CHAR_W'($urandom_range(255)),
                              tcw_pkg::RROW_W'($urandom_range(31)),
                              tcw_pkg::RCOL_W'($urandom_range(127)));
                end
                sent += len;
            end
            else
            begin
                send_item(tcw_pkg::CMD_CLEAR, tcw_pkg::CHAR_W'($urandom_range(255)),
                          tcw_pkg::RROW_W'($urandom_range(31)),
                          tcw_pkg::RCOL_W'($urandom_range(127)));
                sent++;
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        for (int i = 0; i < 40; i++)
            send_item(($urandom_range(3) == 0) ? tcw_pkg::CMD_READ : tcw_pkg::CMD_WRITE,
                      tcw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h21)),
                      tcw_pkg::RROW_W'($urandom_range(tcw_pkg::HEIGHT - 1)),
                      tcw_pkg::RCOL_W'($urandom_range(tcw_pkg::WIDTH - 1)));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        blank_screen();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_traffic(200, 0, 0);
        test_traffic(200, 83, 0);
        test_traffic(200, 0, 83);
        test_traffic(200, 10, 10);
        test_output_backpressure();

        @(negedge clk);
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (console_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (console_results_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, console_results_q.size());
        end

        $display("Sent %0d items, checked %0d results, %0d mismatches", n_sent, n_checked, errors);
        $display("Covered %0d scrolls, %0d wraps, %0d clamped tabs, %0d off-screen reads",
                 n_scrolls, n_wraps, n_tab_clamp, n_reads_oor);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
